### rtl/pdbr_pkg.sv
package pdbr_pkg;

  // field and port widths
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned OUT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned BYTES_W    = 3;
  localparam int unsigned CHANS_W    = 4;
  localparam int unsigned STEP_W     = 24;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

  // register reset values
  localparam logic [BYTES_W-1:0] BYTES_RESET = 3'd2;
  localparam logic [CHANS_W-1:0] CHANS_RESET = 4'd2;

  // ratio constants, unsigned Q8.16
  localparam logic [STEP_W-1:0] STEP_ONE = 24'h010000;
  localparam logic [STEP_W-1:0] STEP_MIN = 24'd1024;

  // box weights never exceed 1.0
  localparam int unsigned        WEIGHT_W   = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // quotient bits of the box rounding division
  localparam int unsigned BOX_Q_W = 8;

  // upsample run length limit
  localparam int unsigned        RUN_W    = 6;
  localparam logic [RUN_W-1:0]   RUN_LAST = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MONO_LD,
    S_MONO_DIV,
    S_MONO_SET,
    S_BOX_MUL,
    S_BOX_ADD,
    S_BOX_LD,
    S_BOX_DIV,
    S_BOX_OUT,
    S_UP_EMIT
  } pdbr_state_t;

  // multiplier weight operand
  typedef enum logic {
    WSEL_BOX,
    WSEL_LEFT
  } pdbr_wsel_t;

  typedef struct packed {
    logic       accept;
    logic       mono_load;
    logic       box_load;
    logic       div_step;
    logic       mono_set;
    logic       mul;
    pdbr_wsel_t wsel;
    logic       acc_add;
    logic       box_emit;
    logic       up_emit;
    logic       phase_wrap;
  } pdbr_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic div_done;
    logic box_mode;
    logic wn_gt_one;
    logic phase_lt_one;
    logic up_last;
    logic out_free;
  } pdbr_status_t;

endpackage

### rtl/pdbr_in_if.sv
interface pdbr_in_if import pdbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

### rtl/pdbr_out_if.sv
interface pdbr_out_if import pdbr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_sample;
  logic                    last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink (input valid, input out_sample, input last_of_run, output ready);
endinterface

### rtl/pdbr_div.sv
module pdbr_div import pdbr_pkg::*; #(
  parameter int unsigned RW  = 41,
  parameter int unsigned DVW = 27,
  parameter int unsigned CW  = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           step,
  input  logic [RW-1:0]  rem_init,
  input  logic [DVW-1:0] dvd_init,
  input  logic [RW-1:0]  divisor_init,
  input  logic [CW-1:0]  cnt_init,
  output logic [DVW-1:0] quot,
  output logic           last
);

  logic [RW-1:0]  rem_r;
  logic [DVW-1:0] dvd_r;
  logic [RW-1:0]  div_r;
  logic [CW-1:0]  cnt_r;
  logic [RW:0]    trial;
  logic           ge;
  logic [RW:0]    diff;

  // restoring step: one quotient bit shifted in per cycle while step is high
  assign trial = {rem_r, dvd_r[DVW-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      div_r <= divisor_init;
    end else if (step) begin
      rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
      dvd_r <= {dvd_r[DVW-2:0], ge};
    end
  end

  // steps left in the current division, less one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= cnt_init;
    end else if (step && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quot = dvd_r;
  assign last = (cnt_r == '0);

endmodule

### rtl/pdbr_dp.sv
module pdbr_dp import pdbr_pkg::*; #(
  parameter int unsigned MAX_CHANNELS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [SAMPLE_W-1:0]     sample_word,
  input  pdbr_cmd_t               cmd,
  output pdbr_status_t            status,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_sample,
  output logic                    out_last
);

  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned CIW   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned SUMW  = $clog2(MAX_CHANNELS) + 8;
  localparam int unsigned MW    = FB + 8;
  localparam int unsigned PW    = MW + WEIGHT_W;
  localparam int unsigned ACCW  = FB + 33;
  localparam int unsigned NW    = FB + 33;
  localparam int unsigned RW    = FB + STEP_W + 1;
  localparam int unsigned DVW   = SUMW + FB;
  localparam int unsigned DCW   = $clog2(DVW);
  localparam int unsigned PHW   = WEIGHT_W + 1;
  localparam logic [MW:0] HALF  = (MW + 1)'(1) << (FB - 1);

  // saturate a sign and magnitude to signed 8 bits
  function automatic logic [OUT_W-1:0] sat8(input logic neg, input logic [8:0] mag);
    logic [8:0] m;
    logic [OUT_W-1:0] res;
    if (neg) begin
      m   = (mag > 9'd128) ? 9'd128 : mag;
      res = OUT_W'(9'd0 - m);
    end else begin
      m   = (mag > 9'd127) ? 9'd127 : mag;
      res = m[OUT_W-1:0];
    end
    return res;
  endfunction

  logic [BYTES_W-1:0]     bytes_r;
  logic [CHANS_W-1:0]     chans_r;
  logic [STEP_W-1:0]      step_r;
  logic [CIW-1:0]         idx_r;
  logic signed [SUMW-1:0] sum_r;
  logic [STEP_W-1:0]      wn_r;
  logic [ACCW-1:0]        acc_r;
  logic [PHW-1:0]         phase_r;
  logic [RUN_W-1:0]       run_cnt_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_sample_r;
  logic                   out_last_r;
  logic [MW-1:0]          mono_mag_r;
  logic                   mono_neg_r;
  logic [PW-1:0]          prod_r;

  logic [BYTES_W-1:0]     bytes_eff;
  logic [CIW-1:0]         chans_eff;
  logic [STEP_W-1:0]      step_eff;
  logic [STEP_W-1:0]      step_new;
  logic signed [7:0]      red;
  logic signed [SUMW-1:0] red_ext;
  logic [SUMW-1:0]        sum_mag;
  logic [CIW-1:0]         idx_inc;
  logic                   wn_gt_one;
  logic [WEIGHT_W-1:0]    weight_box;
  logic [WEIGHT_W-1:0]    left;
  logic [WEIGHT_W-1:0]    weight;
  logic [PW-1:0]          prod_c;
  logic [ACCW-1:0]        prod_ext;
  logic [ACCW-1:0]        sprod;
  logic                   acc_neg;
  logic [NW-1:0]          acc2;
  logic [NW-1:0]          den_ext;
  logic [NW-1:0]          n_box;
  logic [RW-1:0]          rem_init;
  logic [DVW-1:0]         dvd_init;
  logic [RW-1:0]          divisor_init;
  logic [DCW-1:0]         cnt_init;
  logic [DVW-1:0]         quot;
  logic                   div_done;
  logic [PHW-1:0]         p_next;
  logic                   p_next_ge;
  logic                   up_last;
  logic [MW:0]            mono_rnd;
  logic [OUT_W-1:0]       box_sample;
  logic [OUT_W-1:0]       up_sample;
  logic                   emit;

  // effective register values
  always_comb begin
    if (bytes_r == '0) begin
      bytes_eff = BYTES_W'(1);
    end else if (bytes_r > BYTES_W'(4)) begin
      bytes_eff = BYTES_W'(4);
    end else begin
      bytes_eff = bytes_r;
    end
  end

  always_comb begin
    if (chans_r == '0) begin
      chans_eff = CIW'(1);
    end else if ({1'b0, chans_r} > 5'(MAX_CHANNELS)) begin
      chans_eff = CIW'(MAX_CHANNELS);
    end else begin
      chans_eff = CIW'(chans_r);
    end
  end

  assign step_eff = (step_r < STEP_MIN) ? STEP_MIN : step_r;
  assign step_new = (cfg_data[STEP_W-1:0] < STEP_MIN) ? STEP_MIN : cfg_data[STEP_W-1:0];

  // sample reduction to signed 8 bits
  always_comb begin
    unique case (bytes_eff)
      3'd1:    red = signed'(sample_word[7:0] ^ 8'h80);
      3'd2:    red = signed'(sample_word[15:8]);
      3'd3:    red = signed'(sample_word[23:16]);
      default: red = signed'(sample_word[31:24]);
    endcase
  end

  assign red_ext = SUMW'(red);
  assign idx_inc = idx_r + 1'b1;
  assign sum_mag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  // box weight operands
  assign wn_gt_one  = wn_r > STEP_ONE;
  assign weight_box = wn_gt_one ? WEIGHT_ONE : wn_r[WEIGHT_W-1:0];
  assign left       = WEIGHT_ONE - wn_r[WEIGHT_W-1:0];
  assign weight     = (cmd.wsel == WSEL_LEFT) ? left : weight_box;
  assign prod_c     = PW'(mono_mag_r) * PW'(weight);

  // signed weighted mono
  assign prod_ext = ACCW'(prod_r);
  assign sprod    = mono_neg_r ? (ACCW'(0) - prod_ext) : prod_ext;

  // rounding numerator 2|acc| + den, one add or subtract
  assign acc_neg = acc_r[ACCW-1];
  assign acc2    = {acc_r[ACCW-2:0], 1'b0};
  assign den_ext = NW'(step_eff) << FB;
  assign n_box   = acc_neg ? (den_ext - acc2) : (den_ext + acc2);

  // divider operands: box rounding or channel average
  always_comb begin
    if (cmd.box_load) begin
      rem_init     = n_box[NW-1:BOX_Q_W];
      dvd_init     = {n_box[BOX_Q_W-1:0], {(DVW - BOX_Q_W){1'b0}}};
      divisor_init = {step_eff, {(FB + 1){1'b0}}};
      cnt_init     = DCW'(BOX_Q_W - 1);
    end else begin
      rem_init     = '0;
      dvd_init     = {sum_mag, {FB{1'b0}}};
      divisor_init = RW'(chans_eff);
      cnt_init     = DCW'(DVW - 1);
    end
  end

  pdbr_div #(
    .RW  (RW),
    .DVW (DVW),
    .CW  (DCW)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (cmd.mono_load | cmd.box_load),
    .step         (cmd.div_step),
    .rem_init     (rem_init),
    .dvd_init     (dvd_init),
    .divisor_init (divisor_init),
    .cnt_init     (cnt_init),
    .quot         (quot),
    .last         (div_done)
  );

  // upsample phase
  assign p_next    = phase_r + PHW'(step_eff[WEIGHT_W-1:0]);
  assign p_next_ge = p_next >= PHW'(WEIGHT_ONE);
  assign up_last   = p_next_ge || (run_cnt_r == RUN_LAST);

  // output rounding
  assign mono_rnd   = {1'b0, mono_mag_r} + HALF;
  assign up_sample  = sat8(mono_neg_r, mono_rnd[MW:FB]);
  assign box_sample = sat8(acc_neg, {1'b0, quot[BOX_Q_W-1:0]});
  assign emit       = cmd.box_emit | cmd.up_emit;

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= BYTES_RESET;
      chans_r     <= CHANS_RESET;
      step_r      <= STEP_ONE;
      idx_r       <= '0;
      sum_r       <= '0;
      wn_r        <= STEP_ONE;
      acc_r       <= '0;
      phase_r     <= '0;
      run_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        sum_r <= sum_r + red_ext;
        idx_r <= (idx_inc >= chans_eff) ? '0 : idx_inc;
      end
      if (cmd.mono_load) begin
        sum_r <= '0;
      end
      if (cmd.mono_set) begin
        run_cnt_r <= '0;
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + sprod;
        if (wn_gt_one) begin
          wn_r <= wn_r - STEP_ONE;
        end
      end
      if (cmd.box_emit) begin
        acc_r <= sprod;
        wn_r  <= step_eff - STEP_W'(left);
      end
      if (cmd.up_emit) begin
        run_cnt_r <= run_cnt_r + 1'b1;
        if (!up_last) begin
          phase_r <= p_next;
        end else if (p_next_ge) begin
          phase_r <= p_next - PHW'(WEIGHT_ONE);
        end else begin
          phase_r <= '0;
        end
      end
      if (cmd.phase_wrap) begin
        phase_r <= phase_r - PHW'(WEIGHT_ONE);
      end
      // output register
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BYTES: begin
            bytes_r <= cfg_data[BYTES_W-1:0];
            idx_r   <= '0;
            sum_r   <= '0;
          end
          REG_CHANS: begin
            chans_r <= cfg_data[CHANS_W-1:0];
            idx_r   <= '0;
            sum_r   <= '0;
          end
          REG_STEP: begin
            step_r  <= cfg_data[STEP_W-1:0];
            wn_r    <= step_new;
            acc_r   <= '0;
            phase_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mono_load) begin
      mono_neg_r <= sum_r[SUMW-1];
    end
    if (cmd.mono_set) begin
      mono_mag_r <= quot[MW-1:0];
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (emit) begin
      out_sample_r <= cmd.box_emit ? box_sample : up_sample;
      out_last_r   <= cmd.box_emit ? 1'b1 : up_last;
    end
  end

  assign status.frame_last   = idx_inc >= chans_eff;
  assign status.div_done     = div_done;
  assign status.box_mode     = step_eff > STEP_ONE;
  assign status.wn_gt_one    = wn_gt_one;
  assign status.phase_lt_one = phase_r < PHW'(WEIGHT_ONE);
  assign status.up_last      = up_last;
  assign status.out_free     = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_sample = signed'(out_sample_r);
  assign out_last   = out_last_r;

endmodule

### rtl/pdbr_ctrl.sv
module pdbr_ctrl import pdbr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pdbr_status_t status,
  output pdbr_cmd_t    cmd
);

  pdbr_state_t state_r;
  pdbr_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.frame_last) begin
            state_nxt = S_MONO_LD;
          end
        end
      end
      S_MONO_LD: begin
        cmd.mono_load = 1'b1;
        state_nxt     = S_MONO_DIV;
      end
      S_MONO_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = S_MONO_SET;
        end
      end
      S_MONO_SET: begin
        cmd.mono_set = 1'b1;
        state_nxt    = status.box_mode ? S_BOX_MUL : S_UP_EMIT;
      end
      S_BOX_MUL: begin
        cmd.mul   = 1'b1;
        cmd.wsel  = WSEL_BOX;
        state_nxt = S_BOX_ADD;
      end
      S_BOX_ADD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = status.wn_gt_one ? S_IDLE : S_BOX_LD;
      end
      S_BOX_LD: begin
        cmd.box_load = 1'b1;
        cmd.mul      = 1'b1;
        cmd.wsel     = WSEL_LEFT;
        state_nxt    = S_BOX_DIV;
      end
      S_BOX_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = S_BOX_OUT;
        end
      end
      S_BOX_OUT: begin
        if (status.out_free) begin
          cmd.box_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_UP_EMIT: begin
        if (!status.phase_lt_one) begin
          cmd.phase_wrap = 1'b1;
          state_nxt      = S_IDLE;
        end else if (status.out_free) begin
          cmd.up_emit = 1'b1;
          if (status.up_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/pcm_downmix_box_resampler.sv
// channel   direction  handshake      payload
// in_ch     in         valid / ready  sample_word[31:0], one channel sample
// out_ch    out        valid / ready  out_sample[7:0] signed, last_of_run
// cfg_*     in         cfg_wr_en      cfg_index[1:0], cfg_data[23:0], no read-back
//
// a sample that does not close a frame only adds to the channel sum; in_ready stays high
// a frame-closing sample also runs the channel average (one quotient bit per cycle in the
//   shared divider); a box step without result then multiplies and adds, a box result also
//   divides for rounding and is emitted, or upsampled results are emitted one after another
// output stalls hold the sequencer only when a new result meets a full output register
// reset is synchronous, active low; registers return to 2 bytes, 2 channels, ratio 1.0
module pcm_downmix_box_resampler import pdbr_pkg::*; #(
  parameter int unsigned MAX_CHANNELS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pdbr_in_if.sink               in_ch,
  pdbr_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pdbr_cmd_t    cmd;
  pdbr_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic signed [OUT_W-1:0] out_sample;
  logic         out_last;

  // sequencer
  pdbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  pdbr_dp #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_word (in_ch.sample_word),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_sample  (out_sample),
    .out_last    (out_last)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.out_sample  = out_sample;
  assign out_ch.last_of_run = out_last;

endmodule

### rtl/pdbr_checker.sv
module pdbr_checker import pdbr_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_sample,
  input logic                    last_of_run
);

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(last_of_run))
    else $error("result payload changed while stalled");

  // after reset the block is ready and has nothing to offer
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

  // an accepted sample never produces a result in the next cycle
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || $past(out_valid && !out_ready))
    else $error("result appeared straight after an input transaction");

endmodule

bind pcm_downmix_box_resampler pdbr_checker u_pdbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sample  (out_ch.out_sample),
  .last_of_run (out_ch.last_of_run)
);
